// ----- design/if3_pkg.sv -----
`timescale 1ns / 1ps
package if3_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = 17;
  localparam int LANES     = 3;
  localparam int TAPS      = 9;
  localparam int SUM_W     = 13;
  localparam int PIX_W     = 32;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_KIND   = 3'd3,
    REG_EDGE_MODE     = 3'd4
  } reg_index_t;

  typedef enum logic [2:0] {
    KIND_IDENTITY = 3'd0,
    KIND_BOX      = 3'd1,
    KIND_SHARPEN  = 3'd2,
    KIND_SOBEL_X  = 3'd3,
    KIND_SOBEL_Y  = 3'd4,
    KIND_LAPLACE  = 3'd5
  } kind_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } border_t;

  typedef struct packed {
    logic    due;
    logic    last;
    border_t border;
  } item_ctl_t;

  localparam logic signed [3:0] W_SHARPEN [TAPS] =
    '{4'sd0, -4'sd1, 4'sd0, -4'sd1, 4'sd5, -4'sd1, 4'sd0, -4'sd1, 4'sd0};
  localparam logic signed [3:0] W_SOBEL_X [TAPS] =
    '{-4'sd1, 4'sd0, 4'sd1, -4'sd2, 4'sd0, 4'sd2, -4'sd1, 4'sd0, 4'sd1};
  localparam logic signed [3:0] W_SOBEL_Y [TAPS] =
    '{-4'sd1, -4'sd2, -4'sd1, 4'sd0, 4'sd0, 4'sd0, 4'sd1, 4'sd2, 4'sd1};
  localparam logic signed [3:0] W_LAPLACE [TAPS] =
    '{4'sd0, 4'sd1, 4'sd0, 4'sd1, -4'sd4, 4'sd1, 4'sd0, 4'sd1, 4'sd0};

  function automatic logic signed [3:0] weight(kind_t kind, int idx);
    logic signed [3:0] w;
    case (kind)
      KIND_BOX:     w = 4'sd1;
      KIND_SHARPEN: w = W_SHARPEN[idx];
      KIND_SOBEL_X: w = W_SOBEL_X[idx];
      KIND_SOBEL_Y: w = W_SOBEL_Y[idx];
      KIND_LAPLACE: w = W_LAPLACE[idx];
      default:      w = (idx == 4) ? 4'sd1 : 4'sd0;
    endcase
    return w;
  endfunction

endpackage

// ----- design/image_filter_3x3.sv -----
`timescale 1ns / 1ps
// channel | signals                              | payload
// s       | s_tvalid s_tready s_tdata s_tuser    | pixel in, tuser = opcode
// m       | m_tvalid m_tready m_tdata m_tlast    | filtered pixel, tlast = frame end
// cfg     | cfg_valid cfg_ready cfg_index cfg_data | register write
//
// one item per clock unless m stalls; s1, window, lane sum, then output registers
// line buffers are one dual-port ram, at most one read and one write per clock
// reset clears positions, window and valid bits; line buffers need no clearing
// a stall on m holds the whole pipeline and drops s_tready
module image_filter_3x3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // in_ch0, in_ch1, in_ch2, in_ch3
  input  logic        s_tuser,   // opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // out_ch0, out_ch1, out_ch2, out_ch3
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [11:0] frame_width;
  logic [15:0] frame_height;
  logic [2:0]  channel_count;
  logic [2:0]  kernel_kind;
  logic        edge_mode;

  logic [11:0]            width;
  logic [15:0]            height;
  if3_pkg::kind_t         kind;
  logic                   three;

  logic                      adv;
  logic                      push;
  logic [if3_pkg::COL_W-1:0] col;
  if3_pkg::item_ctl_t        ctl;
  logic [31:0]               px;

  logic                      s1_valid;
  logic [if3_pkg::COL_W-1:0] s1_col;
  logic [31:0]               s1_px;
  if3_pkg::item_ctl_t        s1_ctl;
  logic                      s1_fwd;
  logic [31:0]               fwd_a;
  logic [31:0]               fwd_b;
  logic [63:0]               rdata;
  logic [31:0]               s1_a;
  logic [31:0]               s1_b;

  logic [31:0]               win [if3_pkg::TAPS];
  logic                      w_valid;
  logic                      w_last;
  if3_pkg::border_t          w_border;

  logic                      s3_valid;
  logic                      s3_last;
  logic [31:0]               s3_centre;
  logic [7:0]                lane_out [if3_pkg::LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= 12'd640;
      frame_height  <= 16'd480;
      channel_count <= 3'd3;
      kernel_kind   <= 3'd0;
      edge_mode     <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        if3_pkg::REG_FRAME_WIDTH:   frame_width   <= cfg_data[11:0];
        if3_pkg::REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        if3_pkg::REG_CHANNEL_COUNT: channel_count <= cfg_data[2:0];
        if3_pkg::REG_KERNEL_KIND:   kernel_kind   <= cfg_data[2:0];
        if3_pkg::REG_EDGE_MODE:     edge_mode     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width == '0) begin
      width = 12'd1;
    end else if (frame_width > if3_pkg::MAX_WIDTH) begin
      width = 12'(if3_pkg::MAX_WIDTH);
    end else begin
      width = frame_width;
    end
    height = (frame_height == '0) ? 16'd1 : frame_height;
    kind   = (kernel_kind > 3'd5) ? if3_pkg::KIND_IDENTITY : if3_pkg::kind_t'(kernel_kind);
    three  = channel_count == 3'd3;
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign px       = (s_tuser == if3_pkg::OP_FLUSH) ? 32'd0 : s_tdata;

  if3_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (s_tvalid && s_tready),
    .opcode (s_tuser),
    .width  (width),
    .height (height),
    .push   (push),
    .col    (col),
    .ctl    (ctl)
  );

  // upper row in the high half, middle row in the low half
  if3_ram #(
    .WIDTH (64),
    .DEPTH (if3_pkg::MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (adv && s1_valid),
    .waddr (s1_col),
    .wdata ({s1_b, s1_px}),
    .re    (adv),
    .raddr (col),
    .rdata (rdata)
  );

  // forward the previous write when it hits the column just read
  assign s1_a = s1_fwd ? fwd_a : rdata[63:32];
  assign s1_b = s1_fwd ? fwd_b : rdata[31:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col <= col;
      s1_px  <= px;
      s1_ctl <= ctl;
      s1_fwd <= s1_valid && (s1_col == col);
      fwd_a  <= s1_b;
      fwd_b  <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < if3_pkg::TAPS; i++) begin
        win[i] <= '0;
      end
    end else if (adv && s1_valid) begin
      for (int r = 0; r < 3; r++) begin
        win[r*3]   <= win[r*3+1];
        win[r*3+1] <= win[r*3+2];
      end
      win[2] <= s1_a;
      win[5] <= s1_b;
      win[8] <= s1_px;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_last    <= s1_ctl.last;
      w_border  <= s1_ctl.border;
      s3_last   <= w_last;
      s3_centre <= win[4];
    end
  end

  for (genvar ch = 0; ch < if3_pkg::LANES; ch++) begin : g_lane
    logic [71:0] taps;
    always_comb begin
      for (int i = 0; i < if3_pkg::TAPS; i++) begin
        taps[8*i +: 8] = win[i][8*ch +: 8];
      end
    end
    if3_lane u_lane (
      .clk       (clk),
      .en        (adv),
      .taps      (taps),
      .border    (w_border),
      .kind      (kind),
      .edge_mode (edge_mode),
      .result    (lane_out[ch])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      w_valid  <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= push;
      w_valid  <= s1_valid && s1_ctl.due;
      s3_valid <= w_valid;
      m_tvalid <= s3_valid;
    end
  end

  // merge lanes with the passed-through channels
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata[7:0]   <= lane_out[0];
      m_tdata[15:8]  <= three ? lane_out[1] : s3_centre[15:8];
      m_tdata[23:16] <= three ? lane_out[2] : s3_centre[23:16];
      m_tdata[31:24] <= s3_centre[31:24];
      m_tlast        <= s3_last;
    end
  end

endmodule

// ----- design/if3_ram.sv -----
`timescale 1ns / 1ps
module if3_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/if3_ctrl.sv -----
`timescale 1ns / 1ps
module if3_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic                     opcode,
  input  logic [11:0]              width,
  input  logic [15:0]              height,
  output logic                     push,
  output logic [if3_pkg::COL_W-1:0] col,
  output if3_pkg::item_ctl_t       ctl
);

  logic [if3_pkg::COL_W-1:0] in_column, in_column_next;
  logic [if3_pkg::ROW_W-1:0] in_row, in_row_next;
  logic [if3_pkg::COL_W-1:0] out_column, out_column_next;
  logic [15:0]               out_row, out_row_next;

  logic                      complete;
  logic [if3_pkg::COL_W:0]   in_col_inc;
  logic [if3_pkg::COL_W:0]   out_col_inc;
  logic [16:0]               out_row_inc;

  always_comb begin
    complete    = in_row >= {1'b0, height};
    push        = accept && ((opcode == if3_pkg::OP_FLUSH) ? complete : !complete);
    in_col_inc  = {1'b0, in_column} + 1'b1;
    out_col_inc = {1'b0, out_column} + 1'b1;
    out_row_inc = {1'b0, out_row} + 1'b1;

    ctl.due           = (in_row >= 2) || (in_row == 1 && in_column != '0);
    ctl.border.top    = out_row == '0;
    ctl.border.bottom = out_row_inc >= {1'b0, height};
    ctl.border.left   = out_column == '0;
    ctl.border.right  = out_col_inc >= width;
    ctl.last          = ctl.border.right && ctl.border.bottom;
    col               = in_column;

    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (push) begin
      if (in_col_inc >= width) begin
        in_column_next = '0;
        in_row_next    = in_row + 1'b1;
      end else begin
        in_column_next = in_col_inc[if3_pkg::COL_W-1:0];
      end
      if (ctl.due) begin
        if (ctl.last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (out_col_inc >= width) begin
          out_column_next = '0;
          out_row_next    = out_row_inc[15:0];
        end else begin
          out_column_next = out_col_inc[if3_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

`ifndef SYNTHESIS
  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    push && ctl.due && ctl.last |=> in_column == '0 && in_row == '0 && out_row == '0)
    else $error("frame end did not clear positions");
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("item pushed without a transfer");
  a_no_emit_holds_out: assert property (@(posedge clk) disable iff (rst)
    !(push && ctl.due) |=> $stable(out_row) && $stable(out_column))
    else $error("output position moved without an output");
`endif

endmodule

// ----- design/if3_lane.sv -----
`timescale 1ns / 1ps
module if3_lane (
  input  logic                clk,
  input  logic                en,
  input  logic [71:0]         taps,
  input  if3_pkg::border_t    border,
  input  if3_pkg::kind_t      kind,
  input  logic                edge_mode,
  output logic [7:0]          result
);

  logic signed [if3_pkg::SUM_W-1:0] sum;
  logic signed [if3_pkg::SUM_W-1:0] sum_q;
  logic                             box_q;
  logic [23:0]                      prod;
  logic signed [if3_pkg::SUM_W-1:0] val;

  always_comb begin
    int  rr;
    int  cc;
    logic outside;
    logic [7:0] pix;
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rr = ((r == 0 && border.top) || (r == 2 && border.bottom)) ? 1 : r;
        cc = ((c == 0 && border.left) || (c == 2 && border.right)) ? 1 : c;
        outside = (rr != r) || (cc != c);
        pix = taps[8*(rr*3+cc) +: 8];
        if (!outside || edge_mode) begin
          sum = sum + ($signed({5'b0, pix}) *
                       if3_pkg::SUM_W'(if3_pkg::weight(kind, r*3+c)));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q <= sum;
      box_q <= kind == if3_pkg::KIND_BOX;
    end
  end

  // floor(s/9) as s*3641>>15, exact for box sums up to 9*255
  always_comb begin
    prod = sum_q[11:0] * 12'd3641;
    val  = box_q ? $signed({4'b0, prod[23:15]}) : sum_q;
    if (val < 0) begin
      result = 8'd0;
    end else if (val > 255) begin
      result = 8'd255;
    end else begin
      result = val[7:0];
    end
  end

endmodule

// ----- tb/image_filter_3x3_checker.sv -----
`timescale 1ns / 1ps
module image_filter_3x3_checker
  import if3_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          pending,
  output int          errors
);

  typedef struct packed {
    logic [31:0] pix;
    logic        last;
  } filtered_t;

  // taps in raster order, rows top to bottom
  localparam int COEF [6][9] = '{
    '{0, 0, 0, 0, 1, 0, 0, 0, 0},
    '{1, 1, 1, 1, 1, 1, 1, 1, 1},
    '{0, -1, 0, -1, 5, -1, 0, -1, 0},
    '{-1, 0, 1, -2, 0, 2, -1, 0, 1},
    '{-1, -2, -1, 0, 0, 0, 1, 2, 1},
    '{0, 1, 0, 1, -4, 1, 0, 1, 0}
  };

  filtered_t   expected_q [$];
  logic [11:0] fw;
  logic [15:0] fh;
  logic [2:0]  chans;
  logic [2:0]  kind;
  logic        edge_rep;
  logic [31:0] line_mem [2*MAX_WIDTH];
  logic [31:0] win [9];
  int unsigned icol, irow, ocol, orow;

  function automatic int unsigned width_now();
    int unsigned w;
    w = fw;
    if (w == 0) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned height_now();
    return (fh == 0) ? 1 : fh;
  endfunction

  function automatic logic [7:0] filter_lane(int ch);
    int sum, rr, cc, k;
    bit in_frame;
    sum = 0;
    k = (kind > KIND_LAPLACE) ? int'(KIND_IDENTITY) : int'(kind);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        rr = r;
        cc = c;
        in_frame = 1;
        if (r == 0 && orow < 1) in_frame = 0;
        if (r == 2 && orow + 1 >= height_now()) in_frame = 0;
        if (c == 0 && ocol < 1) in_frame = 0;
        if (c == 2 && ocol + 1 >= width_now()) in_frame = 0;
        if (!in_frame) begin
          if (!edge_rep) continue;
          if (r == 0 && orow < 1) rr = 1;
          if (r == 2 && orow + 1 >= height_now()) rr = 1;
          if (c == 0 && ocol < 1) cc = 1;
          if (c == 2 && ocol + 1 >= width_now()) cc = 1;
        end
        sum += COEF[k][r*3+c] * int'(win[rr*3+cc][8*ch +: 8]);
      end
    end
    if (k == KIND_BOX) sum = sum / 9;
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    return sum[7:0];
  endfunction

  task automatic accept_pixel(input logic op, input logic [31:0] d);
    logic [31:0] px, a, b;
    int unsigned col;
    bit due, three;
    filtered_t res;
    if (op == OP_PIXEL) begin
      if (irow >= height_now()) return;
      px = d;
    end else begin
      if (irow < height_now()) return;
      px = '0;
    end
    col = (icol < MAX_WIDTH) ? icol : MAX_WIDTH - 1;
    a = line_mem[MAX_WIDTH + col];
    b = line_mem[col];
    line_mem[MAX_WIDTH + col] = b;
    line_mem[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3] = win[r*3+1];
      win[r*3+1] = win[r*3+2];
    end
    win[2] = a;
    win[5] = b;
    win[8] = px;
    due = irow >= 2 || (irow == 1 && icol >= 1);
    icol++;
    if (icol >= width_now()) begin
      icol = 0;
      irow++;
    end
    if (!due) return;
    three = chans == 3;
    res.pix[7:0]   = filter_lane(0);
    res.pix[15:8]  = three ? filter_lane(1) : win[4][15:8];
    res.pix[23:16] = three ? filter_lane(2) : win[4][23:16];
    res.pix[31:24] = win[4][31:24];
    res.last = ocol + 1 >= width_now() && orow + 1 >= height_now();
    expected_q.push_back(res);
    if (res.last) begin
      icol = 0;
      irow = 0;
      ocol = 0;
      orow = 0;
    end else begin
      ocol++;
      if (ocol >= width_now()) begin
        ocol = 0;
        orow++;
      end
    end
  endtask

  always @(posedge clk) begin
    filtered_t want;
    if (rst) begin
      fw = 640;
      fh = 480;
      chans = 3;
      kind = KIND_IDENTITY;
      edge_rep = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
      foreach (win[i]) win[i] = '0;
      icol = 0;
      irow = 0;
      ocol = 0;
      orow = 0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_WIDTH:   fw = cfg_data[11:0];
          REG_FRAME_HEIGHT:  fh = cfg_data;
          REG_CHANNEL_COUNT: chans = cfg_data[2:0];
          REG_KERNEL_KIND:   kind = cfg_data[2:0];
          REG_EDGE_MODE:     edge_rep = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected output transfer: data %h last %b", m_tdata, m_tlast);
        end else begin
          want = expected_q.pop_front();
          if (m_tdata !== want.pix || m_tlast !== want.last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected data %h last %b, got data %h last %b",
                       want.pix, want.last, m_tdata, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready) accept_pixel(s_tuser, s_tdata);
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/image_filter_3x3_tb.sv -----
`timescale 1ns / 1ps
module image_filter_3x3_tb;
  import if3_pkg::*;

  localparam int CYCLE_LIMIT = 60000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_tvalid = 0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = OP_PIXEL;
  logic        m_tvalid;
  logic        m_tready = 0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_FRAME_WIDTH;
  logic [15:0] cfg_data = '0;
  int          pending;
  int          errors;

  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_req = 0;
  int          items_sent = 0;
  int          cycles = 0;
  int unsigned cur_w = 640, cur_h = 480;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  image_filter_3x3 uut (.*);

  image_filter_3x3_checker chk (.*);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver side, with a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 0;
        repeat (400) @(posedge clk);
        hold_req = 0;
      end
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send(input logic op, input logic [31:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1;
    s_tuser  <= op;
    s_tdata  <= d;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [15:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    do @(posedge clk); while (pending != 0);
    repeat (12) @(posedge clk);
  endtask

  // unused upper bits of the narrow registers carry random junk
  task automatic configure(input logic [11:0] w, input logic [15:0] h,
                           input logic [2:0] cc, input logic [2:0] k, input logic e);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, {4'($urandom), w});
    write_reg(REG_FRAME_HEIGHT, h);
    write_reg(REG_CHANNEL_COUNT, {13'($urandom), cc});
    write_reg(REG_KERNEL_KIND, {13'($urandom), k});
    write_reg(REG_EDGE_MODE, {15'($urandom), e});
    cfg_valid <= 0;
    cur_w = (w == 0) ? 1 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
    cur_h = (h == 0) ? 1 : h;
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_pixel();
    return {rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  // whole frame; with noise, stray flushes inside it and a stray pixel before the drain
  task automatic send_frame(input bit noise);
    for (int i = 0; i < cur_w * cur_h; i++) begin
      if (noise && $urandom_range(19) == 0) send(OP_FLUSH, 32'($urandom));
      send(OP_PIXEL, rand_pixel());
    end
    if (noise && $urandom_range(3) == 0) send(OP_PIXEL, rand_pixel());
    for (int i = 0; i < cur_w + 3; i++) send(OP_FLUSH, 32'($urandom));
  endtask

  task automatic random_frames(input int budget);
    int stop;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      configure($urandom_range(9) == 0 ? 12'd0 : 12'($urandom_range(1, 10)),
                $urandom_range(9) == 0 ? 16'd0 : 16'($urandom_range(1, 6)),
                3'($urandom), 3'($urandom), 1'($urandom));
      send_frame(1);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: a 3x3 frame of extreme samples, edge replication, sobel x
    configure(12'd3, 16'd3, 3'd3, KIND_SOBEL_X, 1'b1);
    send(OP_FLUSH, '1);
    for (int i = 0; i < 9; i++)
      send(OP_PIXEL, (i % 2) ? 32'hffff_ffff : 32'h0000_0000);
    send(OP_PIXEL, 32'h1234_5678);
    for (int i = 0; i < 6; i++) send(OP_FLUSH, '0);
    send(OP_FLUSH, '1);

    // tallest frame: run part of it, then shorten so the tail drains
    configure(12'd3, 16'hffff, 3'd3, KIND_LAPLACE, 1'b0);
    for (int i = 0; i < 12; i++) send(OP_PIXEL, rand_pixel());
    configure(12'd3, 16'd4, 3'd3, KIND_LAPLACE, 1'b0);
    for (int i = 0; i < cur_w + 3; i++) send(OP_FLUSH, '0);

    // saturated width and zero height: part of a wide row, then narrow it so it drains
    configure(12'hfff, 16'd0, 3'd1, KIND_BOX, 1'b1);
    for (int i = 0; i < 40; i++) send(OP_PIXEL, rand_pixel());
    configure(12'd5, 16'd1, 3'd3, KIND_SHARPEN, 1'b0);
    send(OP_PIXEL, rand_pixel());
    for (int i = 0; i < cur_w + 3; i++) send(OP_FLUSH, '0);

    // block fills up behind a long receiver hold-off
    configure(12'd8, 16'd8, 3'd3, KIND_SOBEL_Y, 1'b1);
    hold_req = 1;
    send_frame(0);

    send_idle_pct = 0;  stall_pct = 0;  random_frames(230);
    send_idle_pct = 86; stall_pct = 0;  random_frames(230);
    send_idle_pct = 0;  stall_pct = 86; random_frames(230);
    send_idle_pct = 16; stall_pct = 16; random_frames(230);

    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/if3_pkg.sv
design/if3_ram.sv
design/if3_ctrl.sv
design/if3_lane.sv
design/image_filter_3x3.sv
tb/image_filter_3x3_checker.sv
tb/image_filter_3x3_tb.sv
